[src/gne_pkg.sv]
// ----------------------------------------------------------------------------
// gne_pkg: shared types and constants for the grid neighbor expander
// Field structs, status codes, register indexes, controller states and the
// neighbor offset tables used by the controller and the datapath.
// ----------------------------------------------------------------------------
package gne_pkg;

  // grid geometry
  localparam int MaxSide  = 64;
  localparam int MapDepth = MaxSide * MaxSide;
  localparam int AddrW    = $clog2(MapDepth);

  // field widths
  localparam int CoordW   = 6;
  localparam int IdxW     = 12;
  localparam int DirW     = 3;
  localparam int CfgSideW = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStartIndex = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGoalIndex  = 3'd3;

  // input function codes
  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [2:0] {
    StSucc    = 3'd0,
    StNone    = 3'd1,
    StAdded   = 3'd2,
    StRefused = 3'd3,
    StAlready = 3'd4,
    StOut     = 3'd5
  } gne_status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SSetup,
    SAdd,
    SQry,
    SQfin
  } gne_state_e;

  typedef struct packed {
    logic              func;
    logic [CoordW-1:0] tile_x;
    logic [CoordW-1:0] tile_y;
  } gne_in_t;

  typedef struct packed {
    gne_status_e       status;
    logic [IdxW-1:0]   successor_index;
    logic [DirW-1:0]   direction;
    logic              last;
  } gne_res_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic setup;
    logic add_chk;
    logic q_step;
    logic q_fin;
  } gne_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic in_grid;
    logic is_query;
    logic q_done;
  } gne_stat_t;

  // column offset of each neighbor, two's complement: NW N NE E SE S SW W
  function automatic logic [1:0] nb_dx(input logic [DirW-1:0] dir);
    logic [1:0] r;
    case (dir)
      3'd0:    r = 2'b11;
      3'd1:    r = 2'b00;
      3'd2:    r = 2'b01;
      3'd3:    r = 2'b01;
      3'd4:    r = 2'b01;
      3'd5:    r = 2'b00;
      3'd6:    r = 2'b11;
      default: r = 2'b11;
    endcase
    return r;
  endfunction

  // row offset of each neighbor, two's complement
  function automatic logic [1:0] nb_dy(input logic [DirW-1:0] dir);
    logic [1:0] r;
    case (dir)
      3'd0:    r = 2'b11;
      3'd1:    r = 2'b11;
      3'd2:    r = 2'b11;
      3'd3:    r = 2'b00;
      3'd4:    r = 2'b01;
      3'd5:    r = 2'b01;
      3'd6:    r = 2'b01;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

[src/gne_ctrl.sv]
// ----------------------------------------------------------------------------
// gne_ctrl: sequencing state machine of the grid neighbor expander
// Runs the map clearing pass, accepts commands and steps the datapath through
// the add check or the eight-neighbor scan.
// ----------------------------------------------------------------------------
module gne_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  gne_pkg::gne_stat_t stat_i,
  output gne_pkg::gne_cmd_t  cmd_o
);

  gne_pkg::gne_state_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gne_pkg::SClear;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      gne_pkg::SClear: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_done) begin
          state_d = gne_pkg::SIdle;
        end
      end
      gne_pkg::SIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = gne_pkg::SSetup;
        end
      end
      gne_pkg::SSetup: begin
        cmd_o.setup = 1'b1;
        if (!stat_i.in_grid) begin
          state_d = gne_pkg::SIdle;
        end else if (stat_i.is_query) begin
          state_d = gne_pkg::SQry;
        end else begin
          state_d = gne_pkg::SAdd;
        end
      end
      gne_pkg::SAdd: begin
        cmd_o.add_chk = 1'b1;
        state_d       = gne_pkg::SIdle;
      end
      gne_pkg::SQry: begin
        cmd_o.q_step = 1'b1;
        if (stat_i.q_done) begin
          state_d = gne_pkg::SQfin;
        end
      end
      gne_pkg::SQfin: begin
        cmd_o.q_fin = 1'b1;
        state_d     = gne_pkg::SIdle;
      end
      default: begin
        state_d = gne_pkg::SIdle;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gne_pkg::SIdle && start_i) |=> state_q == gne_pkg::SSetup)
    else $error("accepted command did not enter setup");

  a_out_of_grid_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gne_pkg::SSetup && !stat_i.in_grid) |=> state_q == gne_pkg::SIdle)
    else $error("out-of-grid command did not finish at once");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gne_pkg::SQry && !stat_i.q_done) |=> state_q == gne_pkg::SQry)
    else $error("neighbor scan left early");
`endif

endmodule

[src/gne_datapath.sv]
// ----------------------------------------------------------------------------
// gne_datapath: registers, obstacle map and result logic
// Holds the configuration, the latched command, the one-bit obstacle map,
// the neighbor scan stage and the registered result beat.
// ----------------------------------------------------------------------------
module gne_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [gne_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gne_pkg::CfgDataW-1:0]  cfg_data_i,
  input  gne_pkg::gne_in_t              item_i,
  input  gne_pkg::gne_cmd_t             cmd_i,
  output gne_pkg::gne_stat_t            stat_o,
  output logic                          res_valid_o,
  output gne_pkg::gne_res_t             res_o
);

  localparam int CW   = gne_pkg::CoordW;
  localparam int SW   = gne_pkg::CfgSideW;
  localparam int PW   = gne_pkg::CoordW + gne_pkg::CfgSideW;
  localparam int AW   = gne_pkg::AddrW;
  localparam int IW   = gne_pkg::IdxW;
  localparam int DW   = gne_pkg::DirW;

  // configuration registers
  logic [SW-1:0] cfg_w_q, cfg_h_q;
  logic [IW-1:0] cfg_start_q, cfg_goal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= SW'(64);
      cfg_h_q     <= SW'(64);
      cfg_start_q <= '0;
      cfg_goal_q  <= IW'(4095);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gne_pkg::CfgGridWidth:  cfg_w_q     <= cfg_data_i[SW-1:0];
        gne_pkg::CfgGridHeight: cfg_h_q     <= cfg_data_i[SW-1:0];
        gne_pkg::CfgStartIndex: cfg_start_q <= cfg_data_i[IW-1:0];
        gne_pkg::CfgGoalIndex:  cfg_goal_q  <= cfg_data_i[IW-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid sides to one through the map side
  logic [SW-1:0] side_w, side_h;
  always_comb begin
    side_w = cfg_w_q;
    side_h = cfg_h_q;
    if (cfg_w_q == '0) begin
      side_w = SW'(1);
    end else if (cfg_w_q > SW'(gne_pkg::MaxSide)) begin
      side_w = SW'(gne_pkg::MaxSide);
    end
    if (cfg_h_q == '0) begin
      side_h = SW'(1);
    end else if (cfg_h_q > SW'(gne_pkg::MaxSide)) begin
      side_h = SW'(gne_pkg::MaxSide);
    end
  end

  // latched command
  logic          func_q;
  logic [CW-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= item_i.func;
      x_q    <= item_i.tile_x;
      y_q    <= item_i.tile_y;
    end
  end

  // direction counter; top bit marks the drain step
  logic [DW:0] d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else if (cmd_i.load) begin
      d_q <= '0;
    end else if (cmd_i.q_step) begin
      d_q <= d_q + 1'b1;
    end
  end

  // neighbor coordinates, two bits of headroom for the sign
  logic [1:0]    dx, dy;
  logic [CW+1:0] nx, ny;
  logic          nb_inside;

  always_comb begin
    dx = gne_pkg::nb_dx(d_q[DW-1:0]);
    dy = gne_pkg::nb_dy(d_q[DW-1:0]);
    nx = {2'b00, x_q} + {{CW{dx[1]}}, dx};
    ny = {2'b00, y_q} + {{CW{dy[1]}}, dy};
    nb_inside = !nx[CW+1] && !ny[CW+1]
             && (nx < {1'b0, side_w}) && (ny < {1'b0, side_h});
  end

  // shared row-major index: tile in setup, neighbor in the scan
  logic [CW-1:0] mul_x, mul_y;
  logic [PW-1:0] prod;
  logic [IW-1:0] idx_c;

  always_comb begin
    mul_x = cmd_i.q_step ? nx[CW-1:0] : x_q;
    mul_y = cmd_i.q_step ? ny[CW-1:0] : y_q;
    prod  = PW'(mul_y) * PW'(side_w);
    idx_c = IW'(prod + PW'(mul_x));
  end

  logic in_grid;
  assign in_grid = ({1'b0, x_q} < side_w) && ({1'b0, y_q} < side_h);

  logic [IW-1:0] tile_idx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      tile_idx_q <= idx_c;
    end
  end

  // clearing sweep address
  logic [AW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // add decision
  logic              is_sg, map_we, rd_q;
  gne_pkg::gne_status_e add_st;
  logic [AW-1:0]     wa;

  always_comb begin
    is_sg  = (tile_idx_q == cfg_start_q) || (tile_idx_q == cfg_goal_q);
    add_st = is_sg ? gne_pkg::StRefused : (rd_q ? gne_pkg::StAlready : gne_pkg::StAdded);
    map_we = cmd_i.clear || (cmd_i.add_chk && !is_sg && !rd_q);
    wa     = cmd_i.clear ? clr_cnt_q : AW'(tile_idx_q);
  end

  // obstacle map: one write port, one registered read port
  logic map_mem [gne_pkg::MapDepth];

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[wa] <= !cmd_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= map_mem[AW'(idx_c)];
  end

  // scan stage: neighbor whose map bit arrives next cycle
  logic          p_vld_q, p_inside_q;
  logic [IW-1:0] p_idx_q;
  logic [DW-1:0] p_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      p_vld_q <= 1'b0;
    end else if (cmd_i.q_step) begin
      p_vld_q <= !d_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_step) begin
      p_inside_q <= nb_inside;
      p_idx_q    <= idx_c;
      p_dir_q    <= d_q[DW-1:0];
    end
  end

  logic qual;
  assign qual = cmd_i.q_step && p_vld_q && p_inside_q && !rd_q;

  // pending successor, held until the next one shows whether it is last
  logic          pend_q;
  logic [IW-1:0] pend_idx_q;
  logic [DW-1:0] pend_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.load) begin
      pend_q <= 1'b0;
    end else if (qual) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qual) begin
      pend_idx_q <= p_idx_q;
      pend_dir_q <= p_dir_q;
    end
  end

  // result beat
  logic              res_valid_q, res_valid_d;
  gne_pkg::gne_res_t res_q, res_d;

  always_comb begin
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (cmd_i.setup && !in_grid) begin
      res_valid_d = 1'b1;
      res_d       = '{gne_pkg::StOut, '0, '0, 1'b1};
    end else if (cmd_i.add_chk) begin
      res_valid_d = 1'b1;
      res_d       = '{add_st, tile_idx_q, '0, 1'b1};
    end else if (qual && pend_q) begin
      res_valid_d = 1'b1;
      res_d       = '{gne_pkg::StSucc, pend_idx_q, pend_dir_q, 1'b0};
    end else if (cmd_i.q_fin) begin
      res_valid_d = 1'b1;
      if (pend_q) begin
        res_d = '{gne_pkg::StSucc, pend_idx_q, pend_dir_q, 1'b1};
      end else begin
        res_d = '{gne_pkg::StNone, '0, '0, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;
  assign stat_o.clr_done = (clr_cnt_q == '1);
  assign stat_o.in_grid  = in_grid;
  assign stat_o.is_query = (func_q == gne_pkg::FuncQuery);
  assign stat_o.q_done   = d_q[DW];

`ifndef SYNTH
  a_only_succ_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |-> res_q.status == gne_pkg::StSucc)
    else $error("non-final beat is not a successor");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |=> !res_valid_q)
    else $error("beat directly after a final beat");

  a_no_mark_start_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_we && !cmd_i.clear) |-> (wa != AW'(cfg_start_q) && wa != AW'(cfg_goal_q)))
    else $error("start or goal tile marked as obstacle");
`endif

endmodule

[src/grid_neighbor_expander_core.sv]
// ----------------------------------------------------------------------------
// grid_neighbor_expander_core: obstacle map with eight-neighbor expansion
// Marks obstacle tiles and lists the free in-grid neighbors of a tile.
//
//  channel   ports                                   handshake
//  command   start_i, busy_o, item_i                 taken when start_i && !busy_o
//  result    res_valid_o, res_o                      one-cycle strobe, no stall
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,  written on valid && ready
//            cfg_data_i
//
// An add passes through setup and the add check before the next command is
// accepted; an out-of-grid command ends after setup. A query passes through
// setup, nine scan steps through the single read port of the obstacle map (the map read
// latency puts the last check one step after the last read) and one closing
// beat. After reset the map is cleared one entry a cycle, all 4096 entries, with
// busy_o high; configuration writes are taken throughout. Results cannot be
// stalled: each beat is on res_o for one cycle only.
// ----------------------------------------------------------------------------
module grid_neighbor_expander_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  gne_pkg::gne_in_t              item_i,
  output logic                          res_valid_o,
  output gne_pkg::gne_res_t             res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gne_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gne_pkg::CfgDataW-1:0]  cfg_data_i
);

  gne_pkg::gne_cmd_t  cmd;
  gne_pkg::gne_stat_t stat;

  // registers accept a write in every cycle
  assign cfg_ready_o = 1'b1;

  gne_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  gne_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for grid_neighbor_expander_core
// Drives add and query commands over a series of grid settings, keeps its
// own obstacle map and neighbor expansion, and compares every result beat
// field by field, in order, against the beats that map predicts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ClkHalf      = 2;
  localparam int ResetCycles  = 11;
  localparam int SettleCycles = 16;
  localparam int MaxGap       = 16;
  localparam int NumPhases    = 12;
  localparam int ItemsPerPhase = 37;
  localparam int LimitNs      = 2_000_000;

  localparam int MaxSide  = gne_pkg::MaxSide;
  localparam int MapDepth = gne_pkg::MapDepth;
  localparam int CoordW   = gne_pkg::CoordW;
  localparam int IdxW     = gne_pkg::IdxW;
  localparam int DirW     = gne_pkg::DirW;
  localparam int CfgSideW = gne_pkg::CfgSideW;
  localparam int CfgIdxW  = gne_pkg::CfgIdxW;
  localparam int CfgDataW = gne_pkg::CfgDataW;

  // neighbor visiting order
  typedef enum logic [gne_pkg::DirW-1:0] {
    NbNW, NbN, NbNE, NbE, NbSE, NbS, NbSW, NbW
  } nb_dir_e;

  // --------------------------------------------------------------------------
  // obstacle map mirror and the beats it still owes
  // --------------------------------------------------------------------------
  class obstacle_map_model;
    bit                  blocked [MapDepth];
    logic [CfgSideW-1:0] width_reg;
    logic [CfgSideW-1:0] height_reg;
    logic [IdxW-1:0]     start_reg;
    logic [IdxW-1:0]     goal_reg;
    gne_pkg::gne_res_t   owed_beats [$];
    int                  mismatches;

    function new();
      width_reg  = CfgSideW'(MaxSide);
      height_reg = CfgSideW'(MaxSide);
      start_reg  = '0;
      goal_reg   = '1;
      mismatches = 0;
      foreach (blocked[i]) blocked[i] = 1'b0;
    endfunction

    // zero reads as one, anything past the array side saturates
    function int side_of(logic [CfgSideW-1:0] side_reg);
      if (side_reg == 0) return 1;
      if (side_reg > MaxSide) return MaxSide;
      return int'(side_reg);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        gne_pkg::CfgGridWidth:  width_reg  = data[CfgSideW-1:0];
        gne_pkg::CfgGridHeight: height_reg = data[CfgSideW-1:0];
        gne_pkg::CfgStartIndex: start_reg  = data[IdxW-1:0];
        gne_pkg::CfgGoalIndex:  goal_reg   = data[IdxW-1:0];
        default: ;
      endcase
    endfunction

    function int col_step(nb_dir_e dir);
      case (dir)
        NbNW, NbSW, NbW: return -1;
        NbN, NbS:        return 0;
        default:         return 1;
      endcase
    endfunction

    function int row_step(nb_dir_e dir);
      case (dir)
        NbNW, NbN, NbNE: return -1;
        NbE, NbW:        return 0;
        default:         return 1;
      endcase
    endfunction

    function void owe_beat(gne_pkg::gne_status_e st, int idx, int dir, bit last);
      gne_pkg::gne_res_t beat;
      beat.status          = st;
      beat.successor_index = IdxW'(idx);
      beat.direction       = DirW'(dir);
      beat.last            = last;
      owed_beats.insert(owed_beats.size(), beat);
    endfunction

    // update the map and queue the beats one accepted command causes
    function void take_command(gne_pkg::gne_in_t cmd);
      int cols, rows, x, y, idx, nx, ny, found;
      cols = side_of(width_reg);
      rows = side_of(height_reg);
      x    = int'(cmd.tile_x);
      y    = int'(cmd.tile_y);
      if (x >= cols || y >= rows) begin
        owe_beat(gne_pkg::StOut, 0, 0, 1'b1);
        return;
      end
      if (cmd.func == gne_pkg::FuncAdd) begin
        idx = y * cols + x;
        // start and goal win over an existing obstacle
        if (idx == int'(start_reg) || idx == int'(goal_reg)) begin
          owe_beat(gne_pkg::StRefused, idx, 0, 1'b1);
        end else if (blocked[idx]) begin
          owe_beat(gne_pkg::StAlready, idx, 0, 1'b1);
        end else begin
          blocked[idx] = 1'b1;
          owe_beat(gne_pkg::StAdded, idx, 0, 1'b1);
        end
        return;
      end
      found = 0;
      for (int d = 0; d < 8; d++) begin
        nx = x + col_step(nb_dir_e'(d));
        ny = y + row_step(nb_dir_e'(d));
        if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
        idx = ny * cols + nx;
        if (blocked[idx]) continue;
        owe_beat(gne_pkg::StSucc, idx, d, 1'b0);
        found++;
      end
      if (found == 0) begin
        owe_beat(gne_pkg::StNone, 0, 0, 1'b1);
      end else begin
        owed_beats[owed_beats.size()-1].last = 1'b1;
      end
    endfunction

    // compare one result beat with the oldest owed beat
    function void check_beat(gne_pkg::gne_res_t got);
      gne_pkg::gne_res_t want;
      if (owed_beats.size() == 0) begin
        $error("unexpected result beat: status %0d index %0d direction %0d last %0d",
               got.status, got.successor_index, got.direction, got.last);
        mismatches++;
        return;
      end
      want = owed_beats.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.successor_index !== want.successor_index) begin
        $error("successor_index: expected %0d, actual %0d",
               want.successor_index, got.successor_index);
        mismatches++;
      end
      if (got.direction !== want.direction) begin
        $error("direction: expected %0d, actual %0d", want.direction, got.direction);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and the block
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  gne_pkg::gne_in_t    item_i      = '0;
  logic                res_valid_o;
  gne_pkg::gne_res_t   res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  obstacle_map_model model = new();
  bit                steady = 1'b0;

  grid_neighbor_expander_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // check every result beat on the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) model.check_beat(res_o);
  end

  // hard stop
  initial begin
    #(LimitNs);
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drive helpers
  // --------------------------------------------------------------------------
  function automatic gne_pkg::gne_in_t cmd_at(logic func, int x, int y);
    gne_pkg::gne_in_t cmd;
    cmd.func   = func;
    cmd.tile_x = CoordW'(x);
    cmd.tile_y = CoordW'(y);
    return cmd;
  endfunction

  // mostly near the current focus so obstacles cluster, sometimes anywhere
  function automatic int pick_coord(int span, int center);
    int lo, hi, roll;
    roll = $urandom_range(0, 9);
    lo   = (center > 3) ? center - 3 : 0;
    hi   = (center + 3 < span) ? center + 3 : span - 1;
    if (roll < 7) return $urandom_range(lo, hi);
    if (roll < 9) return $urandom_range(0, span - 1);
    return $urandom_range(0, (1 << CoordW) - 1);
  endfunction

  // hold start high until the block takes the beat; keep it high on gap 0
  task automatic send_cmd(input gne_pkg::gne_in_t cmd);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= cmd;
    do @(posedge clk_i); while (busy_o);
    model.take_command(cmd);
  endtask

  // drop start and wait for every owed beat, then let the block wind down
  task automatic drain();
    start_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // leave valid high; the caller drops it after the last write
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_reg(idx, data);
  endtask

  task automatic set_grid(input logic [CfgDataW-1:0] w_data, input logic [CfgDataW-1:0] h_data,
                          input logic [CfgDataW-1:0] s_data, input logic [CfgDataW-1:0] g_data);
    put_reg(gne_pkg::CfgGridWidth, w_data);
    put_reg(gne_pkg::CfgGridHeight, h_data);
    put_reg(gne_pkg::CfgStartIndex, s_data);
    put_reg(gne_pkg::CfgGoalIndex, g_data);
    // an index past the register list must change nothing
    put_reg(CfgIdxW'(gne_pkg::CfgGoalIndex + 1 + $urandom_range(0, 3)),
            CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                  cols, rows, cx, cy, cells, roll;
    logic [CfgSideW-1:0] w_side, h_side;
    logic [CfgDataW-1:0] w_data, h_data, s_data, g_data;
    gne_pkg::gne_in_t    cmd;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: start at the origin, goal at the far corner
    send_cmd(cmd_at(gne_pkg::FuncAdd, 0, 0));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 63, 63));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 1, 0));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 1, 0));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 0, 1));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 0, 0));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 1, 1));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 0, 0));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 1, 0));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 63, 63));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 62, 62));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 63, 0));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 0, 63));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 31, 42));
    drain();

    // 5x3 grid with junk above the side bits; goal sits on an obstacle
    set_grid(12'hF85, 12'hF03, 12'd7, 12'd1);
    send_cmd(cmd_at(gne_pkg::FuncAdd, 1, 0));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 2, 1));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 5, 0));
    send_cmd(cmd_at(gne_pkg::FuncAdd, 0, 3));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 63, 63));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 4, 2));
    send_cmd(cmd_at(gne_pkg::FuncQuery, 2, 1));

    // random phases, each under its own grid setting
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: begin w_side = 7'd64;  h_side = 7'd64;  end
        1: begin w_side = 7'd1;   h_side = 7'd1;   end
        2: begin w_side = 7'd0;   h_side = 7'd5;   end
        3: begin w_side = 7'd4;   h_side = 7'd0;   end
        4: begin w_side = 7'd127; h_side = 7'd127; end
        5: begin w_side = 7'd2;   h_side = 7'd2;   end
        6: begin w_side = 7'd1;   h_side = 7'd64;  end
        7: begin w_side = 7'd64;  h_side = 7'd1;   end
        default: begin
          w_side = CfgSideW'(($urandom_range(0, 3) == 0) ? $urandom_range(65, 127)
                                                         : $urandom_range(1, 12));
          h_side = CfgSideW'(($urandom_range(0, 3) == 0) ? $urandom_range(65, 127)
                                                         : $urandom_range(1, 12));
        end
      endcase
      w_data = CfgDataW'($urandom);
      h_data = CfgDataW'($urandom);
      w_data[CfgSideW-1:0] = w_side;
      h_data[CfgSideW-1:0] = h_side;
      cells = model.side_of(w_side) * model.side_of(h_side);
      roll  = $urandom_range(0, 3);
      if (roll == 0) begin
        s_data = '0;
        g_data = '1;
      end else if (roll == 1) begin
        s_data = CfgDataW'($urandom);
        g_data = CfgDataW'($urandom);
      end else begin
        s_data = CfgDataW'($urandom_range(0, cells - 1));
        g_data = CfgDataW'($urandom_range(0, cells - 1));
      end
      set_grid(w_data, h_data, s_data, g_data);

      cols   = model.side_of(model.width_reg);
      rows   = model.side_of(model.height_reg);
      cx     = $urandom_range(0, cols - 1);
      cy     = $urandom_range(0, rows - 1);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 24) == 0) drain();
        if ($urandom_range(0, 9) == 0) begin
          cx = $urandom_range(0, cols - 1);
          cy = $urandom_range(0, rows - 1);
        end
        cmd = cmd_at(($urandom_range(0, 99) < 45) ? gne_pkg::FuncAdd : gne_pkg::FuncQuery,
                     pick_coord(cols, cx), pick_coord(rows, cy));
        send_cmd(cmd);
      end
    end

    drain();
    if (model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/gne_pkg.sv
src/gne_ctrl.sv
src/gne_datapath.sv
src/grid_neighbor_expander_core.sv
dv/tb_top.sv
